@@ hdl/assert_macros.svh @@
// Assertion macros shared by the stencil RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check a property on every clock edge outside reset.
`define LDS_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) \
    else $error(msg);

// Check that a condition is followed by another in the next cycle.
`define LDS_ASSERT_NEXT(lbl, pre, post, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (pre) |=> (post)) \
    else $error(msg);

`endif

@@ hdl/lds_pkg.sv @@
// Shared types and constants of the Laplacian diffusion stencil.
package lds_pkg;

  localparam int FIELD_W    = 48;
  localparam int COEF_W     = 47;
  localparam int PANEL_W    = 3;
  localparam int IDX_W      = 6;
  localparam int IN_DATA_W  = 384;
  localparam int OUT_DATA_W = 160;
  localparam int CFG_ADDR_W = 2;
  localparam int WORD_W     = 192;

  // Register indexes of the configuration port.
  localparam logic [CFG_ADDR_W-1:0] CFG_DOUBLE_DT = 2'd0;
  localparam logic [CFG_ADDR_W-1:0] CFG_COEF_X    = 2'd1;
  localparam logic [CFG_ADDR_W-1:0] CFG_COEF_Y    = 2'd2;

  // Sequencer states.
  typedef enum logic [3:0] {
    S_IDLE,
    S_RD0,
    S_RD1,
    S_RD2,
    S_RD3,
    S_RD4,
    S_WB,
    S_MUL,
    S_TERM,
    S_DIV,
    S_OUT
  } state_e;

  // Operations of the shared multiplier.
  typedef enum logic [2:0] {
    MOP_KX,
    MOP_KY,
    MOP_DX2,
    MOP_DY2,
    MOP_TERM
  } mop_e;

endpackage

@@ hdl/lds_ram.sv @@
// Generic single-write, single-read RAM with registered read data.
module lds_ram #(
  parameter int WIDTH = 192,
  parameter int DEPTH = 128
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  // Write port and registered read port.
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

@@ hdl/laplacian_diffusion_stencil_top.sv @@
// Five-point Laplacian diffusion stencil over a raster stream of grid points.
//
// Input channel s_axis: one grid point per item, panel by panel, row by row,
// column by column. Each point is stored in two row RAMs (old fields with x,
// and y with next-level fields). When the point of row r arrives, interior
// point (r-1, c) is finished and one item leaves on m_axis; edge and margin
// points give no item.
// An item that gives no result passes from accept through the read states
// S_RD0 to S_RD3, S_RD4 for the last read data and the write back S_WB, then
// returns to idle for the next accept. For an interior item, after the reads,
// one 32x32 multiplier runs each 64x64 product in 4 steps (two coefficients,
// two squared spacings and six term products) and a restoring divider
// delivers each of the six terms in up to 49 steps. The divider loop sets the
// rate; a new point is accepted only once the sequencer is back in idle.
// The output register holds a result until m_axis_tready_i is high; the next
// point is accepted meanwhile, and a following result waits for the slot.
// Configuration writes take effect at once; users must make them only
// while idle, which the block does not enforce. Reset clears the position
// counters, state, configuration and output valid, but not the row RAMs.
`include "assert_macros.svh"

module laplacian_diffusion_stencil_top #(
  parameter int GRID_ROWS = 64,
  parameter int GRID_COLS = 64,
  parameter int PANELS    = 6,
  parameter int MARGIN    = 2
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  // height_old, uwind_old, vwind_old, height_next, uwind_next, vwind_next,
  // coord_x, coord_y (48 bits each, lowest first)
  input  logic [lds_pkg::IN_DATA_W-1:0]     s_axis_tdata_i,
  input  logic                              s_axis_tvalid_i,
  output logic                              s_axis_tready_o,
  // panel_index (3), row_index (6), col_index (6), height_out, uwind_out,
  // vwind_out (48 each), one zero pad bit
  output logic [lds_pkg::OUT_DATA_W-1:0]    m_axis_tdata_o,
  // div_fault
  output logic [0:0]                        m_axis_tuser_o,
  output logic                              m_axis_tlast_o,
  output logic                              m_axis_tvalid_o,
  input  logic                              m_axis_tready_i,
  input  logic                              cfg_we_i,
  input  logic [lds_pkg::CFG_ADDR_W-1:0]    cfg_addr_i,
  input  logic [lds_pkg::COEF_W-1:0]        cfg_wdata_i
);

  import lds_pkg::*;

  localparam int RW          = $clog2(GRID_ROWS);
  localparam int CW          = $clog2(GRID_COLS);
  localparam int RAM1_DEPTH  = 2 << CW;
  localparam int RAM2_DEPTH  = 1 << CW;

  // Control state
  state_e          state_q, state_d;
  mop_e            mop_q, mop_d;
  logic [1:0]      mstep_q, mstep_d;
  logic [2:0]      t_q, t_d;
  logic [5:0]      cnt_q, cnt_d;

  // Position counters and configuration
  logic [RW-1:0]      row_q;
  logic [CW-1:0]      col_q;
  logic [PANEL_W-1:0] panel_q;
  logic [COEF_W-1:0]  dts_q, kcx_q, kcy_q;

  // Item payload
  logic [IN_DATA_W-1:0] in_q;
  logic                 emit_q, last_q;
  logic [PANEL_W-1:0]   opanel_q;
  logic [IDX_W-1:0]     orow_q, ocol_q;
  logic [WORD_W-1:0]    ctr_q, r2_q, p1_q, m1_q, nxt_q;
  logic [FIELD_W-1:0]   yp1_q, y_hold_q;
  logic [49:0]          d2_q [6];
  logic [48:0]          dxd_q, dyd_q;
  logic                 fault_q;
  logic [COEF_W-1:0]    kx_q, ky_q;
  logic [96:0]          dx2_q, dy2_q;
  logic [FIELD_W-1:0]   term_q [6];
  logic [127:0]         acc_q;
  logic [114:0]         rem_q;
  logic [144:0]         dv_q;
  logic [FIELD_W-1:0]   quo_q;

  // Output register
  logic                  m_valid_q;
  logic [OUT_DATA_W-1:0] m_data_q;
  logic                  m_user_q, m_last_q;

  // RAM ports
  logic              r1_we, r2_we;
  logic [CW:0]       r1_waddr, r1_raddr;
  logic [CW-1:0]     r2_waddr, r2_raddr;
  logic [WORD_W-1:0] r1_wdata, r1_rdata, r2_wdata, r2_rdata;

  logic [10:0]     r_ext, c_ext, r_m1;
  logic            emit_now, last_now, in_acc, out_load;
  logic [CW-1:0]   col_p1, col_m1;

  lds_ram #(.WIDTH(WORD_W), .DEPTH(RAM1_DEPTH)) u_ram_old (
    .clk_i  (clk_i),
    .we_i   (r1_we),
    .waddr_i(r1_waddr),
    .wdata_i(r1_wdata),
    .raddr_i(r1_raddr),
    .rdata_o(r1_rdata)
  );

  lds_ram #(.WIDTH(WORD_W), .DEPTH(RAM2_DEPTH)) u_ram_next (
    .clk_i  (clk_i),
    .we_i   (r2_we),
    .waddr_i(r2_waddr),
    .wdata_i(r2_wdata),
    .raddr_i(r2_raddr),
    .rdata_o(r2_rdata)
  );

  // Position decode
  assign r_ext    = 11'(row_q);
  assign c_ext    = 11'(col_q);
  assign r_m1     = r_ext - 11'd1;
  assign col_p1   = col_q + CW'(1);
  assign col_m1   = col_q - CW'(1);
  assign emit_now = (r_ext >= 11'(MARGIN + 1)) && (r_ext < 11'(GRID_ROWS - MARGIN + 1)) &&
                    (c_ext >= 11'(MARGIN)) && (c_ext < 11'(GRID_COLS - MARGIN));
  assign last_now = (r_ext == 11'(GRID_ROWS - MARGIN)) &&
                    (c_ext == 11'(GRID_COLS - MARGIN - 1));
  assign in_acc   = s_axis_tvalid_i && s_axis_tready_o;
  assign out_load = (state_q == S_OUT) && (!m_valid_q || m_axis_tready_i);

  assign s_axis_tready_o = (state_q == S_IDLE);

  // RAM addressing: rows alternate by parity in the old-field store
  always_comb begin
    r1_raddr = {~row_q[0], col_q};
    r2_raddr = col_q;
    unique case (state_q)
      S_RD1:   begin
        r1_raddr = {row_q[0], col_q};
        r2_raddr = col_p1;
      end
      S_RD2:   r1_raddr = {~row_q[0], col_p1};
      S_RD3:   r1_raddr = {~row_q[0], col_m1};
      default: ;
    endcase
  end

  assign r1_we    = (state_q == S_WB);
  assign r2_we    = (state_q == S_WB);
  assign r1_waddr = {row_q[0], col_q};
  assign r2_waddr = col_q;
  assign r1_wdata = {in_q[335:288], in_q[143:0]};
  assign r2_wdata = {in_q[287:144], in_q[383:336]};

  // Second differences and spacings of the finished point
  logic [49:0] d2x_w [3];
  logic [49:0] d2y_w [3];
  logic [48:0] dxd_w, dyd_w;
  always_comb begin
    logic [49:0] ec, ea, eb, ep, em;
    for (int f = 0; f < 3; f++) begin
      ec = {{2{ctr_q[48*f+47]}}, ctr_q[48*f +: 48]};
      ea = {{2{in_q[48*f+47]}}, in_q[48*f +: 48]};
      eb = {{2{r2_q[48*f+47]}}, r2_q[48*f +: 48]};
      ep = {{2{p1_q[48*f+47]}}, p1_q[48*f +: 48]};
      em = {{2{m1_q[48*f+47]}}, m1_q[48*f +: 48]};
      d2x_w[f] = ea - {ec[48:0], 1'b0} + eb;
      d2y_w[f] = ep - {ec[48:0], 1'b0} + em;
    end
    dxd_w = {in_q[335], in_q[335:288]} - {r2_q[191], r2_q[191:144]};
    dyd_w = {yp1_q[47], yp1_q} - {y_hold_q[47], y_hold_q};
  end

  // Term operand selection
  logic              axis;
  logic [49:0]       d2_sel, d2_mag;
  logic              d2_neg;
  logic [48:0]       dxm, dym;
  logic [COEF_W-1:0] coef_sel;
  logic              term_zero;
  assign axis      = t_q[0];
  assign d2_sel    = d2_q[t_q];
  assign d2_neg    = d2_sel[49];
  assign d2_mag    = d2_neg ? 50'(50'd0 - d2_sel) : d2_sel;
  assign dxm       = dxd_q[48] ? 49'(49'd0 - dxd_q) : dxd_q;
  assign dym       = dyd_q[48] ? 49'(49'd0 - dyd_q) : dyd_q;
  assign coef_sel  = axis ? ky_q : kx_q;
  assign term_zero = (axis ? (dyd_q == '0) : (dxd_q == '0)) || (d2_sel == '0) ||
                     (coef_sel == '0);

  // Shared multiplier: one 32x32 partial product a step, four steps a product
  logic [63:0]  mul_a, mul_b, pp;
  logic [31:0]  a_part, b_part;
  logic [127:0] pp_sh, acc_sum;
  logic [COEF_W-1:0] coef_sat;
  always_comb begin
    unique case (mop_q)
      MOP_KX:   begin mul_a = 64'(dts_q); mul_b = 64'(kcx_q); end
      MOP_KY:   begin mul_a = 64'(dts_q); mul_b = 64'(kcy_q); end
      MOP_DX2:  begin mul_a = 64'(dxm);   mul_b = 64'(dxm);   end
      MOP_DY2:  begin mul_a = 64'(dym);   mul_b = 64'(dym);   end
      MOP_TERM: begin mul_a = 64'(coef_sel); mul_b = 64'(d2_mag); end
      default:  begin mul_a = '0; mul_b = '0; end
    endcase
    a_part = mstep_q[0] ? mul_a[63:32] : mul_a[31:0];
    b_part = mstep_q[1] ? mul_b[63:32] : mul_b[31:0];
    pp     = a_part * b_part;
    unique case (mstep_q)
      2'd0:    pp_sh = {64'd0, pp};
      2'd3:    pp_sh = {pp, 64'd0};
      default: pp_sh = {32'd0, pp, 32'd0};
    endcase
    acc_sum  = ((mstep_q == 2'd0) ? 128'd0 : acc_q) + pp_sh;
    coef_sat = (|acc_sum[127:63]) ? {COEF_W{1'b1}} : acc_sum[62:16];
  end

  // Divider step and term saturation
  logic         div_ge, div_ovf, div_fin;
  logic [114:0] rem_sub;
  logic [47:0]  q_fin, q_lim, q_sat, term_val;
  always_comb begin
    div_ge   = {30'd0, rem_q} >= dv_q;
    rem_sub  = rem_q - dv_q[114:0];
    div_ovf  = (cnt_q == 6'd48) && div_ge;
    div_fin  = div_ovf || (cnt_q == 6'd0);
    q_fin    = {quo_q[46:0], div_ge};
    q_lim    = d2_neg ? 48'h8000_0000_0000 : 48'h7FFF_FFFF_FFFF;
    q_sat    = (div_ovf || (q_fin > q_lim)) ? q_lim : q_fin;
    term_val = d2_neg ? 48'(48'd0 - q_sat) : q_sat;
  end

  // Saturated sums of the three fields
  logic [FIELD_W-1:0] sum_out [3];
  always_comb begin
    logic [49:0] s;
    for (int f = 0; f < 3; f++) begin
      s = {{2{nxt_q[48*f+95]}}, nxt_q[48*f+48 +: 48]} +
          {{2{term_q[2*f][47]}}, term_q[2*f]} +
          {{2{term_q[2*f+1][47]}}, term_q[2*f+1]};
      if (!s[49] && (s[48] || s[47])) begin
        sum_out[f] = 48'h7FFF_FFFF_FFFF;
      end else if (s[49] && !(s[48] && s[47])) begin
        sum_out[f] = 48'h8000_0000_0000;
      end else begin
        sum_out[f] = s[47:0];
      end
    end
  end

  // Next state of the sequencer
  always_comb begin
    state_d = state_q;
    mop_d   = mop_q;
    mstep_d = mstep_q;
    t_d     = t_q;
    cnt_d   = cnt_q;
    unique case (state_q)
      S_IDLE: if (s_axis_tvalid_i) state_d = S_RD0;
      S_RD0:  state_d = S_RD1;
      S_RD1:  state_d = S_RD2;
      S_RD2:  state_d = S_RD3;
      S_RD3:  state_d = S_RD4;
      S_RD4:  state_d = S_WB;
      S_WB: begin
        if (emit_q) begin
          state_d = S_MUL;
          mop_d   = MOP_KX;
          mstep_d = 2'd0;
        end else begin
          state_d = S_IDLE;
        end
      end
      S_MUL: begin
        mstep_d = mstep_q + 2'd1;
        if (mstep_q == 2'd3) begin
          unique case (mop_q)
            MOP_KX:  mop_d = MOP_KY;
            MOP_KY:  mop_d = MOP_DX2;
            MOP_DX2: mop_d = MOP_DY2;
            MOP_DY2: begin
              state_d = S_TERM;
              t_d     = 3'd0;
            end
            MOP_TERM: begin
              state_d = S_DIV;
              cnt_d   = 6'd48;
            end
            default: state_d = S_IDLE;
          endcase
        end
      end
      S_TERM: begin
        if (term_zero) begin
          if (t_q == 3'd5) state_d = S_OUT;
          else t_d = t_q + 3'd1;
        end else begin
          state_d = S_MUL;
          mop_d   = MOP_TERM;
          mstep_d = 2'd0;
        end
      end
      S_DIV: begin
        if (div_fin) begin
          if (t_q == 3'd5) begin
            state_d = S_OUT;
          end else begin
            state_d = S_TERM;
            t_d     = t_q + 3'd1;
          end
        end else begin
          cnt_d = cnt_q - 6'd1;
        end
      end
      S_OUT:   if (out_load) state_d = S_IDLE;
      default: state_d = S_IDLE;
    endcase
  end

  // Hold the sequencer state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      mop_q   <= MOP_KX;
      mstep_q <= '0;
      t_q     <= '0;
      cnt_q   <= '0;
    end else begin
      state_q <= state_d;
      mop_q   <= mop_d;
      mstep_q <= mstep_d;
      t_q     <= t_d;
      cnt_q   <= cnt_d;
    end
  end

  // Configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      dts_q <= '0;
      kcx_q <= '0;
      kcy_q <= '0;
    end else if (cfg_we_i) begin
      if (cfg_addr_i == CFG_DOUBLE_DT) dts_q <= cfg_wdata_i;
      if (cfg_addr_i == CFG_COEF_X)    kcx_q <= cfg_wdata_i;
      if (cfg_addr_i == CFG_COEF_Y)    kcy_q <= cfg_wdata_i;
    end
  end

  // Advance panel, row and column after each write back
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      row_q   <= '0;
      col_q   <= '0;
      panel_q <= '0;
    end else if (state_q == S_WB) begin
      if (col_q == CW'(GRID_COLS - 1)) begin
        col_q <= '0;
        if (row_q == RW'(GRID_ROWS - 1)) begin
          row_q <= '0;
          if (panel_q == PANEL_W'(PANELS - 1)) panel_q <= '0;
          else panel_q <= panel_q + PANEL_W'(1);
        end else begin
          row_q <= row_q + RW'(1);
        end
      end else begin
        col_q <= col_q + CW'(1);
      end
    end
  end

  // Datapath: capture reads, multiply, divide
  always_ff @(posedge clk_i) begin
    unique case (state_q)
      S_IDLE: begin
        if (in_acc) begin
          in_q     <= s_axis_tdata_i;
          emit_q   <= emit_now;
          last_q   <= last_now;
          opanel_q <= panel_q;
          orow_q   <= r_m1[IDX_W-1:0];
          ocol_q   <= c_ext[IDX_W-1:0];
        end
      end
      S_RD1: begin
        ctr_q <= r1_rdata;
        nxt_q <= r2_rdata;
      end
      S_RD2: begin
        r2_q  <= r1_rdata;
        yp1_q <= r2_rdata[47:0];
      end
      S_RD3: p1_q <= r1_rdata;
      S_RD4: m1_q <= r1_rdata;
      S_WB: begin
        y_hold_q <= nxt_q[47:0];
        for (int f = 0; f < 3; f++) begin
          d2_q[2*f]   <= d2x_w[f];
          d2_q[2*f+1] <= d2y_w[f];
        end
        dxd_q   <= dxd_w;
        dyd_q   <= dyd_w;
        fault_q <= (dxd_w == '0) || (dyd_w == '0);
      end
      S_MUL: begin
        acc_q <= acc_sum;
        if (mstep_q == 2'd3) begin
          unique case (mop_q)
            MOP_KX:  kx_q  <= coef_sat;
            MOP_KY:  ky_q  <= coef_sat;
            MOP_DX2: dx2_q <= acc_sum[96:0];
            MOP_DY2: dy2_q <= acc_sum[96:0];
            MOP_TERM: begin
              rem_q <= {acc_sum[96:0], 18'd0};
              dv_q  <= {(axis ? dy2_q : dx2_q), 48'd0};
              quo_q <= '0;
            end
            default: ;
          endcase
        end
      end
      S_TERM: if (term_zero) term_q[t_q] <= '0;
      S_DIV: begin
        if (cnt_q != 6'd48) begin
          if (div_ge) rem_q <= rem_sub;
          quo_q <= q_fin;
        end
        dv_q <= dv_q >> 1;
        if (div_fin) term_q[t_q] <= term_val;
      end
      default: ;
    endcase
  end

  // Output register: load when the slot is free, drop on take
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      m_valid_q <= 1'b0;
    end else if (out_load) begin
      m_valid_q <= 1'b1;
    end else if (m_axis_tready_i) begin
      m_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_load) begin
      m_data_q <= {1'b0, sum_out[2], sum_out[1], sum_out[0], ocol_q, orow_q, opanel_q};
      m_user_q <= fault_q;
      m_last_q <= last_q;
    end
  end

  assign m_axis_tvalid_o   = m_valid_q;
  assign m_axis_tdata_o    = m_data_q;
  assign m_axis_tuser_o[0] = m_user_q;
  assign m_axis_tlast_o    = m_last_q;

  // Sequencer checks
  `LDS_ASSERT_NEXT(a_accept_reads, in_acc, state_q == S_RD0, "accepted item did not start reads")
  `LDS_ASSERT_NEXT(a_out_waits, (state_q == S_OUT) && m_valid_q && !m_axis_tready_i, state_q == S_OUT, "result overwrote a waiting item")
  `LDS_ASSERT(a_out_entry, (state_q == S_OUT) |-> ($past(state_q) == S_OUT || $past(state_q) == S_TERM || $past(state_q) == S_DIV), "output state entered without terms")

endmodule

@@ verif/laplacian_diffusion_stencil_top_tb.sv @@
// Testbench of the five-point Laplacian diffusion stencil: streamed grid points, predicted results.
`timescale 1ns / 100ps

module laplacian_diffusion_stencil_top_tb;
  import lds_pkg::*;

  localparam int ROWS = 64;
  localparam int COLS = 64;
  localparam int NPANELS = 6;
  localparam int EDGE = 2;
  localparam logic [CFG_ADDR_W-1:0] CFG_UNUSED = 2'd3;
  localparam logic [46:0] COEF_MAX = 47'h7FFF_FFFF_FFFF;
  localparam longint S48_MAX = 64'sh0000_7FFF_FFFF_FFFF;
  localparam longint S48_MIN = -64'sh0000_8000_0000_0000;
  localparam longint CYCLE_LIMIT = 64'd2_000_000;
  localparam int DRAIN_CYCLES = 400;

  // Kinds of row content produced by the point generator.
  typedef enum int {
    ROW_FULL_RANDOM, ROW_SMOOTH, ROW_FLAT_COORDS, ROW_EXTREMES, ROW_FLAT_X
  } row_kind_e;

  typedef struct packed {
    logic [2:0]  panel;
    logic [5:0]  row;
    logic [5:0]  col;
    logic [47:0] height;
    logic [47:0] uwind;
    logic [47:0] vwind;
    logic        fault;
    logic        last;
  } update_t;

  logic                  clk_i = 1'b0;
  logic                  rst_ni = 1'b0;
  logic [IN_DATA_W-1:0]  s_axis_tdata_i = '0;
  logic                  s_axis_tvalid_i = 1'b0;
  logic                  s_axis_tready_o;
  logic [OUT_DATA_W-1:0] m_axis_tdata_o;
  logic [0:0]            m_axis_tuser_o;
  logic                  m_axis_tlast_o;
  logic                  m_axis_tvalid_o;
  logic                  m_axis_tready_i = 1'b0;
  logic                  cfg_we_i = 1'b0;
  logic [CFG_ADDR_W-1:0] cfg_addr_i = '0;
  logic [COEF_W-1:0]     cfg_wdata_i = '0;

  laplacian_diffusion_stencil_top i_dut (.*);

  always #4 clk_i = ~clk_i;

  // Predictor state: registers, row stores and position.
  logic [46:0] dt2_reg, kx_reg, ky_reg;
  longint old_rows [3][2][COLS];
  longint x_rows [2][COLS];
  longint y_row [COLS];
  longint next_row [3][COLS];
  longint y_held;
  int unsigned at_panel, at_row, at_col;

  logic [IN_DATA_W-1:0] pending_points[$];
  update_t expected_updates[$];
  int mismatches = 0;
  int updates_seen = 0;
  int points_sent = 0;
  int faults_seen = 0;
  int panel_ends_seen = 0;
  bit no_idle = 1'b0;
  longint cycles = 0;

  function automatic longint sext48(logic [47:0] v);
    logic signed [47:0] s;
    s = v;
    return longint'(s);
  endfunction

  function automatic longint sat48(longint v);
    return v > S48_MAX ? S48_MAX : (v < S48_MIN ? S48_MIN : v);
  endfunction

  function automatic logic [46:0] scaled_coef(logic [46:0] k);
    logic [127:0] p;
    p = (128'(dt2_reg) * 128'(k)) >> 16;
    return p > 128'(COEF_MAX) ? COEF_MAX : p[46:0];
  endfunction

  // Diffusion term: coef * d2 * 2^18 / diff^2, toward zero, saturated.
  function automatic longint diffusion_term(logic [46:0] coef, longint d2, longint diff);
    logic [63:0] dm, d2m, lim;
    logic [127:0] num, den, q;
    if (diff == 0 || d2 == 0 || coef == 0) return 0;
    dm = diff < 0 ? 64'(-diff) : 64'(diff);
    d2m = d2 < 0 ? 64'(-d2) : 64'(d2);
    num = (128'(coef) * 128'(d2m)) << 18;
    den = 128'(dm) * 128'(dm);
    q = num / den;
    lim = d2 < 0 ? 64'h0000_8000_0000_0000 : 64'h0000_7FFF_FFFF_FFFF;
    if (q > 128'(lim)) q = 128'(lim);
    return d2 < 0 ? -longint'(q[63:0]) : longint'(q[63:0]);
  endfunction

  // Advance the predictor by one accepted point and queue any update it finishes.
  task automatic predict_point(logic [IN_DATA_W-1:0] pt);
    int unsigned r, c, prv, prv2;
    longint cur_old[3], cur_next[3];
    longint cx, cy, dxd, dyd, ctr, d2x, d2y, sum;
    logic [46:0] kx, ky;
    logic [47:0] res[3];
    update_t u;
    r = at_row;
    c = at_col;
    prv = (r + 1) & 1;
    prv2 = r & 1;
    for (int f = 0; f < 3; f++) begin
      cur_old[f] = sext48(pt[48*f +: 48]);
      cur_next[f] = sext48(pt[48*(3+f) +: 48]);
    end
    cx = sext48(pt[288 +: 48]);
    cy = sext48(pt[336 +: 48]);
    if (r >= EDGE + 1 && r - 1 < ROWS - EDGE && c >= EDGE && c < COLS - EDGE) begin
      dxd = cx - x_rows[prv2][c];
      dyd = y_row[c+1] - y_held;
      kx = scaled_coef(kx_reg);
      ky = scaled_coef(ky_reg);
      for (int f = 0; f < 3; f++) begin
        ctr = old_rows[f][prv][c];
        d2x = cur_old[f] - 2 * ctr + old_rows[f][prv2][c];
        d2y = old_rows[f][prv][c+1] - 2 * ctr + old_rows[f][prv][c-1];
        sum = next_row[f][c] + diffusion_term(kx, d2x, dxd) + diffusion_term(ky, d2y, dyd);
        res[f] = 48'(sat48(sum));
      end
      u.panel = 3'(at_panel);
      u.row = 6'(r - 1);
      u.col = 6'(c);
      u.height = res[0];
      u.uwind = res[1];
      u.vwind = res[2];
      u.fault = (dxd == 0 || dyd == 0);
      u.last = (r - 1 == ROWS - EDGE - 1 && c == COLS - EDGE - 1);
      expected_updates.push_back(u);
    end
    y_held = y_row[c];
    y_row[c] = cy;
    x_rows[prv2][c] = cx;
    for (int f = 0; f < 3; f++) begin
      old_rows[f][prv2][c] = cur_old[f];
      next_row[f][c] = cur_next[f];
    end
    if (++at_col >= COLS) begin
      at_col = 0;
      if (++at_row >= ROWS) begin
        at_row = 0;
        if (++at_panel >= NPANELS) at_panel = 0;
      end
    end
  endtask

  // Point generator with its own raster position.
  int gen_row = 0, gen_col = 0;
  row_kind_e gen_kind = ROW_FULL_RANDOM;
  logic [47:0] flat_x, flat_y;

  function automatic logic [47:0] rand48();
    return 48'({$urandom, $urandom});
  endfunction

  function automatic logic [47:0] small_val();
    return 48'(longint'($urandom_range(0, 2 ** 21)) - (2 ** 20));
  endfunction

  task automatic queue_points(int n, bit directed);
    logic [47:0] fld[8];
    int pick;
    for (int i = 0; i < n; i++) begin
      if (gen_col == 0) begin
        // Pick what kind of row comes next
        if (directed) gen_kind = row_kind_e'(gen_row % 5);
        else begin
          pick = $urandom_range(0, 9);
          gen_kind = pick < 5 ? ROW_SMOOTH : pick < 7 ? ROW_FULL_RANDOM :
                     row_kind_e'(pick - 5);
        end
        flat_x = rand48();
        flat_y = rand48();
      end
      case (gen_kind)
        ROW_FULL_RANDOM: begin
          for (int f = 0; f < 8; f++) fld[f] = rand48();
        end
        ROW_EXTREMES: begin
          for (int f = 0; f < 6; f++)
            fld[f] = ((gen_row + gen_col + f) & 1) ? 48'h8000_0000_0000 : 48'h7FFF_FFFF_FFFF;
          fld[6] = 48'(gen_row << 12) + 48'($urandom_range(0, 15));
          fld[7] = 48'(gen_col << 12) + 48'($urandom_range(0, 15));
        end
        default: begin
          for (int f = 0; f < 6; f++) fld[f] = small_val();
          fld[6] = 48'(gen_row << 16) + 48'($urandom_range(0, 255));
          fld[7] = 48'(gen_col << 16) + 48'($urandom_range(0, 255));
          if (gen_kind == ROW_FLAT_COORDS) begin
            fld[6] = flat_x;
            fld[7] = flat_y;
          end
          if (gen_kind == ROW_FLAT_X) fld[6] = 48'h1234_0000;
        end
      endcase
      pending_points.push_back({fld[7], fld[6], fld[5], fld[4], fld[3], fld[2], fld[1], fld[0]});
      if (++gen_col >= COLS) begin
        gen_col = 0;
        gen_row = (gen_row + 1) % ROWS;
      end
    end
  endtask

  task automatic write_reg(logic [CFG_ADDR_W-1:0] idx, logic [46:0] val);
    @(posedge clk_i);
    cfg_we_i <= 1'b1;
    cfg_addr_i <= idx;
    cfg_wdata_i <= val;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    case (idx)
      CFG_DOUBLE_DT: dt2_reg = val;
      CFG_COEF_X:    kx_reg = val;
      CFG_COEF_Y:    ky_reg = val;
      default: ;
    endcase
  endtask

  task automatic set_coefs(logic [46:0] dt2, logic [46:0] kx, logic [46:0] ky);
    write_reg(CFG_DOUBLE_DT, dt2);
    write_reg(CFG_COEF_X, kx);
    write_reg(CFG_COEF_Y, ky);
  endtask

  // Hold until every point is in and every update is out, then let the block settle.
  task automatic wait_idle();
    while (pending_points.size() != 0 || s_axis_tvalid_i || expected_updates.size() != 0)
      @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
  endtask

  task automatic report_mismatch(string what, longint got, longint want);
    mismatches++;
    $display("mismatch %0s: got %h expected %h (update %0d)", what, got, want, updates_seen);
  endtask

  // Source side: drive points from the pending queue with random idle bursts.
  int src_gap = 0;
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s_axis_tvalid_i <= 1'b0;
      src_gap = 0;
    end else begin
      if (s_axis_tvalid_i && s_axis_tready_o) begin
        predict_point(s_axis_tdata_i);
        points_sent++;
      end
      if (!s_axis_tvalid_i || s_axis_tready_o) begin
        if (src_gap > 0) begin
          src_gap--;
          s_axis_tvalid_i <= 1'b0;
        end else if (pending_points.size() != 0 && !no_idle && $urandom_range(0, 9) == 0) begin
          src_gap = $urandom_range(0, 4);
          s_axis_tvalid_i <= 1'b0;
        end else if (pending_points.size() != 0) begin
          s_axis_tvalid_i <= 1'b1;
          s_axis_tdata_i <= pending_points.pop_front();
        end else begin
          s_axis_tvalid_i <= 1'b0;
        end
      end
    end
  end

  // Sink side: random stall bursts, compare each update with the oldest prediction.
  int sink_gap = 0;
  always @(posedge clk_i or negedge rst_ni) begin
    update_t want;
    if (!rst_ni) begin
      m_axis_tready_i <= 1'b0;
      sink_gap = 0;
    end else begin
      cycles++;
      if (m_axis_tvalid_o && m_axis_tready_i) begin
        if (expected_updates.size() == 0) begin
          report_mismatch("unexpected update", m_axis_tdata_o[63:0], 0);
        end else begin
          want = expected_updates.pop_front();
          if (m_axis_tdata_o[2:0] !== want.panel)
            report_mismatch("panel", m_axis_tdata_o[2:0], want.panel);
          if (m_axis_tdata_o[8:3] !== want.row)
            report_mismatch("row", m_axis_tdata_o[8:3], want.row);
          if (m_axis_tdata_o[14:9] !== want.col)
            report_mismatch("col", m_axis_tdata_o[14:9], want.col);
          if (m_axis_tdata_o[62:15] !== want.height)
            report_mismatch("height", m_axis_tdata_o[62:15], want.height);
          if (m_axis_tdata_o[110:63] !== want.uwind)
            report_mismatch("uwind", m_axis_tdata_o[110:63], want.uwind);
          if (m_axis_tdata_o[158:111] !== want.vwind)
            report_mismatch("vwind", m_axis_tdata_o[158:111], want.vwind);
          if (m_axis_tuser_o[0] !== want.fault)
            report_mismatch("div_fault", m_axis_tuser_o[0], want.fault);
          if (m_axis_tlast_o !== want.last)
            report_mismatch("last_of_panel", m_axis_tlast_o, want.last);
          faults_seen += want.fault;
          panel_ends_seen += want.last;
        end
        updates_seen++;
      end
      if (sink_gap > 0) begin
        sink_gap--;
        m_axis_tready_i <= 1'b0;
      end else if (!no_idle && $urandom_range(0, 7) == 0) begin
        sink_gap = $urandom_range(0, 4);
        m_axis_tready_i <= 1'b0;
      end else begin
        m_axis_tready_i <= 1'b1;
      end
      if (cycles > CYCLE_LIMIT) begin
        $display("timeout after %0d cycles, %0d updates left", cycles, expected_updates.size());
        $display("== FAIL ==");
        $finish;
      end
    end
  end

  initial begin
    dt2_reg = '0;
    kx_reg = '0;
    ky_reg = '0;
    y_held = 0;
    at_panel = 0;
    at_row = 0;
    at_col = 0;
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    repeat (2) @(posedge clk_i);

    // Unit time step, coefficients 0.5 and 2.0; the first directed points form one fully random row
    set_coefs(47'h1_0000, 47'h8000, 47'h2_0000);
    queue_points(20, 1'b1);
    wait_idle();
    queue_points(200, 1'b0);
    wait_idle();

    // Full-scale coefficients drive the terms into saturation
    set_coefs(COEF_MAX, COEF_MAX, COEF_MAX);
    queue_points(200, 1'b0);
    wait_idle();

    // Zero time step gives zero terms; a write to the unused index is dropped
    set_coefs('0, COEF_MAX, 47'h3_0000);
    write_reg(CFG_UNUSED, COEF_MAX);
    queue_points(160, 1'b0);
    wait_idle();

    // Random coefficients, one range at a time
    set_coefs(47'($urandom_range(1, 2 ** 20)), 47'({$urandom, $urandom}),
              47'($urandom_range(0, 2 ** 18)));
    queue_points(240, 1'b0);
    wait_idle();

    // Last stretch of rows, with no idling
    set_coefs(47'($urandom_range(1, 2 ** 17)), 47'($urandom_range(1, 2 ** 17)),
              47'({$urandom, $urandom}));
    no_idle = 1'b1;
    queue_points(180, 1'b0);
    wait_idle();

    $display("sent %0d points over %0d cycles, checked %0d updates", points_sent, cycles,
             updates_seen);
    $display("spacing faults %0d, panel ends %0d, mismatches %0d", faults_seen,
             panel_ends_seen, mismatches);
    if (mismatches == 0 && expected_updates.size() == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule
